@@ src/rpn_pkg.sv @@
// ----------------------------------------------------------------------------
// rpn_pkg
// shared command and error codes and the sequencer state type
// ----------------------------------------------------------------------------
package rpn_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_TOP    = 3'd1,
        CMD_ADD    = 3'd2,
        CMD_SUB    = 3'd3,
        CMD_MUL    = 3'd4,
        CMD_DIV    = 3'd5,
        CMD_REM    = 3'd6,
        CMD_RESULT = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ERR_NONE = 3'd0,
        ERR_FEW  = 3'd1,
        ERR_OVF  = 3'd2,
        ERR_DIV0 = 3'd3,
        ERR_BIG  = 3'd4,
        ERR_FULL = 3'd5
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_B,
        ST_READ_A,
        ST_EXEC,
        ST_DIVIDE,
        ST_WRITE
    } state_t;

    localparam int unsigned DATA_W = 32;

endpackage

@@ src/rpn_stack_calculator.sv @@
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// reverse-polish 32-bit integer calculator on a ram-backed stack
// ----------------------------------------------------------------------------
// channel   signals                              direction
// command   start, busy, command, operand        in
// result    strobe, is_error, value, error_code  out
//
// a command beat is taken when start is high and busy is low
// push and commands refused at once answer from idle; top/result read the top
// entry, add/sub/mul read both entries, div/rem also run the divider (one
// quotient bit a cycle), and a refusal in the exec step ends the command there
// single ram port: entries are read in turn, write-back is a state of its own
// strobe is high for one cycle per command; the receiver cannot stall
// reset clears the entry count, ram contents stay undefined
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [2:0]                 command,
    input  logic signed [31:0]         operand,
    output logic                       strobe,
    output logic                       is_error,
    output logic signed [31:0]         value,
    output logic [2:0]                 error_code
);
    import rpn_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    cmd_t                cmd_reg, cmd_next;
    logic [DATA_W-1:0]   b_reg, b_next;
    logic [DATA_W-1:0]   r_reg, r_next;
    logic                strobe_reg, strobe_next;
    logic                iserr_reg, iserr_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    err_t                err_reg, err_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [DATA_W-1:0]   ram_rdata;

    logic                div_start;
    logic                div_done;
    logic [DATA_W-1:0]   div_quo;
    logic [DATA_W-1:0]   div_rem;

    logic signed [DATA_W:0]     sum_w;
    logic signed [DATA_W:0]     diff_w;
    logic signed [2*DATA_W-1:0] prod_w;

    rpn_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    rpn_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (ram_rdata),
        .divisor   (b_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign sum_w  = {ram_rdata[DATA_W-1], ram_rdata} + {b_reg[DATA_W-1], b_reg};
    assign diff_w = {ram_rdata[DATA_W-1], ram_rdata} - {b_reg[DATA_W-1], b_reg};
    assign prod_w = $signed(ram_rdata) * $signed(b_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cmd_next    = cmd_reg;
        b_next      = b_reg;
        r_next      = r_reg;
        strobe_next = 1'b0;
        iserr_next  = 1'b0;
        value_next  = '0;
        err_next    = ERR_NONE;
        ram_we      = 1'b0;
        ram_addr    = ADDR_W'(count_reg - 1'b1);
        ram_wdata   = operand;
        div_start   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd_t'(command);
                    case (cmd_t'(command))
                        CMD_PUSH:
                        begin
                            strobe_next = 1'b1;
                            if (count_reg >= CNT_W'(STACK_DEPTH))
                            begin
                                iserr_next = 1'b1;
                                err_next   = ERR_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_addr   = ADDR_W'(count_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_TOP:
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                iserr_next  = 1'b1;
                                err_next    = ERR_FEW;
                            end
                            else
                            begin
                                state_next = ST_READ_B;
                            end
                        end
                        CMD_RESULT:
                        begin
                            if (count_reg == '0 || count_reg > CNT_W'(1))
                            begin
                                strobe_next = 1'b1;
                                iserr_next  = 1'b1;
                                err_next    = (count_reg == '0) ? ERR_FEW : ERR_BIG;
                            end
                            else
                            begin
                                state_next = ST_READ_B;
                            end
                        end
                        default:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                strobe_next = 1'b1;
                                iserr_next  = 1'b1;
                                err_next    = ERR_FEW;
                            end
                            else
                            begin
                                state_next = ST_READ_B;
                            end
                        end
                    endcase
                end
            end
            ST_READ_B:
            begin
                // top entry read is in flight
                state_next = ST_READ_A;
                if (cmd_reg == CMD_TOP || cmd_reg == CMD_RESULT)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_READ_A:
            begin
                b_next     = ram_rdata;
                ram_addr   = ADDR_W'(count_reg - 2'd2);
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                ram_addr   = ADDR_W'(count_reg - 2'd2);
                state_next = ST_IDLE;
                case (cmd_reg)
                    CMD_TOP:
                    begin
                        strobe_next = 1'b1;
                        value_next  = ram_rdata;
                    end
                    CMD_RESULT:
                    begin
                        strobe_next = 1'b1;
                        value_next  = ram_rdata;
                        count_next  = '0;
                    end
                    CMD_ADD, CMD_SUB, CMD_MUL:
                    begin
                        if (cmd_reg == CMD_ADD)
                        begin
                            r_next = sum_w[DATA_W-1:0];
                        end
                        else if (cmd_reg == CMD_SUB)
                        begin
                            r_next = diff_w[DATA_W-1:0];
                        end
                        else
                        begin
                            r_next = prod_w[DATA_W-1:0];
                        end
                        if ((cmd_reg == CMD_ADD && sum_w[DATA_W] != sum_w[DATA_W-1])
                            || (cmd_reg == CMD_SUB && diff_w[DATA_W] != diff_w[DATA_W-1])
                            || (cmd_reg == CMD_MUL
                                && prod_w[2*DATA_W-1:DATA_W-1] != {(DATA_W+1){prod_w[DATA_W-1]}}))
                        begin
                            strobe_next = 1'b1;
                            iserr_next  = 1'b1;
                            err_next    = ERR_OVF;
                        end
                        else
                        begin
                            state_next = ST_WRITE;
                        end
                    end
                    default:
                    begin
                        if (b_reg == '0)
                        begin
                            strobe_next = 1'b1;
                            iserr_next  = 1'b1;
                            err_next    = ERR_DIV0;
                        end
                        else if (ram_rdata == {1'b1, {(DATA_W-1){1'b0}}} && (&b_reg))
                        begin
                            strobe_next = 1'b1;
                            iserr_next  = 1'b1;
                            err_next    = ERR_OVF;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIVIDE;
                        end
                    end
                endcase
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    r_next     = (cmd_reg == CMD_DIV) ? div_quo : div_rem;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                ram_we      = 1'b1;
                ram_addr    = ADDR_W'(count_reg - 2'd2);
                ram_wdata   = r_reg;
                count_next  = count_reg - 1'b1;
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        b_reg     <= b_next;
        r_reg     <= r_next;
        iserr_reg <= iserr_next;
        value_reg <= value_next;
        err_reg   <= err_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = strobe_reg;
    assign is_error   = iserr_reg;
    assign value      = value_reg;
    assign error_code = err_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("entry count beyond stack depth");
    a_err_flag: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> (iserr_reg == (err_reg != ERR_NONE)))
        else $error("error flag and code disagree");
    a_err_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_next && iserr_next) |-> count_next == count_reg)
        else $error("failed command changed the stack");
    a_write_strobes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRITE |=> strobe_reg && state_reg == ST_IDLE)
        else $error("write-back without result beat");

endmodule

@@ src/rpn_ram.sv @@
// ----------------------------------------------------------------------------
// rpn_ram
// single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ src/rpn_divider.sv @@
// ----------------------------------------------------------------------------
// rpn_divider
// signed 32-bit restoring divider, one quotient bit per cycle, c truncation
// ----------------------------------------------------------------------------
module rpn_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rpn_pkg::DATA_W-1:0]  dividend,
    input  logic [rpn_pkg::DATA_W-1:0]  divisor,
    output logic                        done,
    output logic [rpn_pkg::DATA_W-1:0]  quotient,
    output logic [rpn_pkg::DATA_W-1:0]  remainder
);
    import rpn_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W:0]   rem_reg, rem_next;
    logic [DATA_W-1:0] dsr_reg, dsr_next;
    logic              qneg_reg, qneg_next;
    logic              rneg_reg, rneg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[DATA_W-1:0], quo_reg[DATA_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            // work on magnitudes, fix signs at the end
            quo_next  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            dsr_next  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            rem_next  = '0;
            qneg_next = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            rneg_next = dividend[DATA_W-1];
            cnt_next  = CNT_W'(DATA_W);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial[DATA_W])
            begin
                rem_next = shifted;
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign done      = done_reg;
    assign quotient  = qneg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign remainder = rneg_reg ? (~rem_reg[DATA_W-1:0] + 1'b1) : rem_reg[DATA_W-1:0];

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(run_reg))
        else $error("divider done without a run");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> !start)
        else $error("divider restarted while busy");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> cnt_reg != '0)
        else $error("divider count underflow");

endmodule

@@ tb/tb_rpn_stack_calculator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rpn_stack_calculator
// drives command beats with random gaps, predicts every result from a local
// stack model and checks each strobed result against the oldest prediction
// ----------------------------------------------------------------------------
module tb_rpn_stack_calculator;
    import rpn_pkg::*;

    localparam int DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic        is_error;
        logic [31:0] value;
        logic [2:0]  error_code;
    } calc_result_t;

    typedef struct {
        cmd_t        cmd;
        logic [31:0] opnd;
        logic        has_exp;
        err_t        exp_err;
        logic [31:0] exp_val;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [2:0]        command;
    logic signed [31:0] operand;
    logic              strobe;
    logic              is_error;
    logic signed [31:0] value;
    logic [2:0]        error_code;

    logic [31:0]  model_stack [DEPTH];
    int           model_count;
    calc_result_t pending_results [$];
    int           mismatch_count;
    int           idle_cycles;

    rpn_stack_calculator #(.STACK_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .operand(operand), .strobe(strobe),
        .is_error(is_error), .value(value), .error_code(error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic calc_result_t pack_result(err_t err, logic [31:0] val);
        calc_result_t r;
        r.is_error = (err != ERR_NONE);
        r.value = val;
        r.error_code = err;
        return r;
    endfunction

    // updates the local stack and returns what the block should answer
    function automatic calc_result_t compute_stack_op(cmd_t cmd, logic [31:0] opnd);
        longint a;
        longint b;
        longint r;
        case (cmd)
            CMD_PUSH:
            begin
                if (model_count >= DEPTH)
                    return pack_result(ERR_FULL, 0);
                model_stack[model_count] = opnd;
                model_count++;
                return pack_result(ERR_NONE, 0);
            end
            CMD_TOP:
            begin
                if (model_count == 0)
                    return pack_result(ERR_FEW, 0);
                return pack_result(ERR_NONE, model_stack[model_count - 1]);
            end
            CMD_RESULT:
            begin
                if (model_count == 0)
                    return pack_result(ERR_FEW, 0);
                if (model_count > 1)
                    return pack_result(ERR_BIG, 0);
                model_count = 0;
                return pack_result(ERR_NONE, model_stack[0]);
            end
            default:
            begin
                if (model_count < 2)
                    return pack_result(ERR_FEW, 0);
                a = longint'(signed'(model_stack[model_count - 2]));
                b = longint'(signed'(model_stack[model_count - 1]));
                case (cmd)
                    CMD_ADD: r = a + b;
                    CMD_SUB: r = a - b;
                    CMD_MUL: r = a * b;
                    default:
                    begin
                        if (b == 0)
                            return pack_result(ERR_DIV0, 0);
                        if (a == -64'sd2147483648 && b == -1)
                            return pack_result(ERR_OVF, 0);
                        r = (cmd == CMD_DIV) ? a / b : a % b;
                    end
                endcase
                if (r < -64'sd2147483648 || r > 64'sd2147483647)
                    return pack_result(ERR_OVF, 0);
                model_stack[model_count - 2] = r[31:0];
                model_count--;
                return pack_result(ERR_NONE, 0);
            end
        endcase
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        return $urandom_range(1, 4);
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'(signed'($urandom_range(0, 20)) - 10);
            4: return 32'($urandom_range(0, 65535)) - 32'd32768;
            default: return $urandom;
        endcase
    endfunction

    // one command beat: hold start until busy is low at an edge
    // with no gap, start stays high straight into the next beat
    task automatic send_beat(cmd_t cmd, logic [31:0] opnd, logic has_exp,
                             err_t exp_err, logic [31:0] exp_val);
        calc_result_t pred;
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            command <= 3'($urandom);
            operand <= $urandom;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        operand <= opnd;
        do @(posedge clk); while (busy);
        pred = compute_stack_op(cmd, opnd);
        if (has_exp && (pred.error_code != exp_err || pred.value != exp_val))
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("table row disagrees with predictor: cmd %0d exp c%0d %h got c%0d %h",
                         cmd, exp_err, exp_val, pred.error_code, pred.value);
        end
        pending_results.push_back(pred);
    endtask

    // checks each strobed result beat
    always @(posedge clk)
    begin
        calc_result_t exp_r;
        if (rst_n && strobe)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: err %0d value %h",
                             error_code, value);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (is_error !== exp_r.is_error || value !== exp_r.value ||
                    error_code !== exp_r.error_code)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp e%0b %h c%0d got e%0b %h c%0d",
                                 exp_r.is_error, exp_r.value, exp_r.error_code,
                                 is_error, value, error_code);
                end
            end
        end
    end

    // watchdog on cycles with no beat in either direction
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows [$];
        stim_row_t row;
        cmd_t c;
        int n;
        int wait_cycles;
        start = 1'b0;
        command = 3'd0;
        operand = 32'd0;
        rst_n = 1'b0;
        model_count = 0;
        mismatch_count = 0;
        idle_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            '{CMD_TOP,    32'd0,         1, ERR_FEW,  32'd0},
            '{CMD_RESULT, 32'd0,         1, ERR_FEW,  32'd0},
            '{CMD_ADD,    32'd0,         1, ERR_FEW,  32'd0},
            '{CMD_PUSH,   32'h7fff_ffff, 1, ERR_NONE, 32'd0},
            '{CMD_TOP,    32'd0,         1, ERR_NONE, 32'h7fff_ffff},
            '{CMD_MUL,    32'd0,         1, ERR_FEW,  32'd0},
            '{CMD_PUSH,   32'd1,         1, ERR_NONE, 32'd0},
            '{CMD_ADD,    32'd0,         1, ERR_OVF,  32'd0},
            '{CMD_RESULT, 32'd0,         1, ERR_BIG,  32'd0},
            '{CMD_SUB,    32'd0,         0, ERR_NONE, 32'd0},
            '{CMD_PUSH,   32'd0,         1, ERR_NONE, 32'd0},
            '{CMD_DIV,    32'd0,         1, ERR_DIV0, 32'd0},
            '{CMD_REM,    32'd0,         1, ERR_DIV0, 32'd0},
            '{CMD_PUSH,   32'h8000_0000, 0, ERR_NONE, 32'd0},
            '{CMD_PUSH,   32'hffff_ffff, 0, ERR_NONE, 32'd0},
            '{CMD_DIV,    32'd0,         1, ERR_OVF,  32'd0},
            '{CMD_REM,    32'd0,         1, ERR_OVF,  32'd0},
            '{CMD_MUL,    32'd0,         1, ERR_OVF,  32'd0},
            '{CMD_PUSH,   32'hffff_fff9, 0, ERR_NONE, 32'd0},
            '{CMD_REM,    32'd0,         0, ERR_NONE, 32'd0},
            '{CMD_SUB,    32'd0,         0, ERR_NONE, 32'd0},
            '{CMD_DIV,    32'd0,         0, ERR_NONE, 32'd0},
            '{CMD_ADD,    32'd0,         0, ERR_NONE, 32'd0},
            '{CMD_TOP,    32'd0,         0, ERR_NONE, 32'd0}
        };
        foreach (rows[i])
        begin
            row = rows[i];
            send_beat(row.cmd, row.opnd, row.has_exp, row.exp_err, row.exp_val);
        end

        // fill to full and probe overflow of the stack
        while (model_count < DEPTH)
            send_beat(CMD_PUSH, pick_operand(), 0, ERR_NONE, 0);
        send_beat(CMD_PUSH, 32'h1234_5678, 1, ERR_FULL, 32'd0);
        send_beat(CMD_TOP, 32'd0, 0, ERR_NONE, 32'd0);
        while (model_count > 1)
            send_beat(cmd_t'($urandom_range(2, 6)), 0, 0, ERR_NONE, 0);
        send_beat(CMD_RESULT, 32'd0, 0, ERR_NONE, 32'd0);

        // random part: mostly well-formed expressions, some noise
        n = 0;
        while (n < 1000)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                send_beat(CMD_PUSH, pick_operand(), 0, ERR_NONE, 0);
                n++;
                repeat ($urandom_range(0, 5))
                begin
                    if (model_count < 2 || $urandom_range(0, 1))
                        send_beat(CMD_PUSH, pick_operand(), 0, ERR_NONE, 0);
                    else
                        send_beat(cmd_t'($urandom_range(1, 6)), $urandom, 0,
                                  ERR_NONE, 0);
                    n++;
                end
                while (model_count > 1)
                begin
                    send_beat(cmd_t'($urandom_range(2, 6)), $urandom, 0,
                              ERR_NONE, 0);
                    n++;
                    // bail out now and then so a failing pair cannot stall here
                    if ($urandom_range(0, 7) == 0)
                        break;
                end
                send_beat(CMD_RESULT, $urandom, 0, ERR_NONE, 0);
                n++;
                // leftovers get folded down by subtracts
                while (model_count > 1 && $urandom_range(0, 3) != 0)
                begin
                    send_beat(CMD_SUB, 0, 0, ERR_NONE, 0);
                    n++;
                end
                if (model_count == 1)
                begin
                    send_beat(CMD_RESULT, 0, 0, ERR_NONE, 0);
                    n++;
                end
            end
            else
            begin
                c = cmd_t'($urandom_range(0, 7));
                send_beat(c, pick_operand(), 0, ERR_NONE, 0);
                n++;
            end
            // keep the stack from saturating forever
            if (model_count > DEPTH - 4 && $urandom_range(0, 1))
            begin
                while (model_count > 0)
                begin
                    if (model_count == 1)
                        send_beat(CMD_RESULT, 0, 0, ERR_NONE, 0);
                    else
                        send_beat(CMD_SUB, 0, 0, ERR_NONE, 0);
                    n++;
                    if (model_count > 1 && $urandom_range(0, 3) == 0)
                        break;
                end
            end
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ rpn_stack_calculator.f @@
src/rpn_pkg.sv
src/rpn_ram.sv
src/rpn_divider.sv
src/rpn_stack_calculator.sv
tb/tb_rpn_stack_calculator.sv
